/* hw/rtl/avclp_pkg.sv */
// Shared types and constants for the AVC length-prefix to Annex-B converter.
package avclp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned LSIZE_W  = 3;
    localparam int unsigned LEN_W    = 32;

    localparam logic [3:0]          CODEC_AVC       = 4'd7;
    localparam logic [POS_W-1:0]    CFG_LEN_POS     = 4'h9;
    localparam logic [1:0]          LEN_MASK        = 2'h3;
    localparam logic [LEN_W-1:0]    START_CODE_WORD = 32'h0100_0000;

    localparam logic [POS_W-1:0]    POS_MAX         = 4'd15;
    localparam logic [POS_W-1:0]    POS_HDR_END     = 4'd10;
    localparam logic [POS_W-1:0]    POS_NALU_END    = 4'd4;
    localparam logic [BYTE_W-1:0]   PKT_SEQ_HDR     = 8'd0;
    localparam logic [BYTE_W-1:0]   PKT_NALU        = 8'd1;
    localparam logic [LSIZE_W-1:0]  HDR_LEN_BYTES   = 3'd2;
    localparam logic [LSIZE_W-1:0]  LSIZE_RESET     = 3'd4;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_TYPE      = 4'd1,
        PH_PRE_HDR   = 4'd2,
        PH_SPS_LEN   = 4'd3,
        PH_SPS_DATA  = 4'd4,
        PH_PPS_COUNT = 4'd5,
        PH_PPS_LEN   = 4'd6,
        PH_PPS_DATA  = 4'd7,
        PH_PRE_NALU  = 4'd8,
        PH_NALU_LEN  = 4'd9,
        PH_NALU_DATA = 4'd10
    } phase_t;

    // One queued result group: a single payload byte, or a whole start code.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              is_sc;
        logic              hdr;
    } group_t;

endpackage

/* hw/rtl/avc_length_prefix_to_annexb.sv */
// Top level: AVC length-prefixed NAL stream to Annex-B byte stream converter.
//
// Input channel (s_*): one byte of a video tag body per beat; s_tuser[0] is set
// on byte 0 of each tag body. Output channel (m_*): Annex-B bytes, with
// m_tuser flags for inserted start-code bytes and for SPS/PPS header output,
// and m_tlast on the final output byte caused by one input beat.
// Each input byte is parsed in the cycle it is accepted; its results sit in a
// two-entry group queue and can leave from the cycle after at the earliest.
// A group is either one passed byte or a 00 00 00 01 start code. The input
// takes one byte per cycle while the queue is not full; the queue lets the
// input keep flowing while a group is being drained.
// s_tready depends only on queue fill, never combinationally on m_tready.
// When the receiver stalls, the head beat holds and the input is taken until
// the queue is full. After reset the parser ignores bytes until a tag start,
// the queue is empty and the NAL length size is four.
module avc_length_prefix_to_annexb (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [0:0] s_tuser,   // [0] tag_start
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] is_start_code, [1] from_header
    output logic       m_tlast
);

    avclp_pkg::phase_t                   phase_reg, phase_next;
    logic [avclp_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [avclp_pkg::LSIZE_W-1:0]       lsize_reg, lsize_next;
    logic [avclp_pkg::LEN_W-1:0]         accum_reg, accum_next;
    logic [avclp_pkg::LSIZE_W-1:0]       pbl_reg, pbl_next;
    logic [avclp_pkg::LEN_W-1:0]         payload_reg, payload_next;

    avclp_pkg::group_t grp_mem_reg [2];
    avclp_pkg::group_t grp_new, head;
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        beat_reg;

    logic s_accept, m_accept, push, pop, emit;

    logic [avclp_pkg::LSIZE_W-1:0] total;
    logic [avclp_pkg::LSIZE_W-1:0] pbl_dec;
    logic [avclp_pkg::LEN_W-1:0]   acc_new;
    logic [avclp_pkg::LEN_W-1:0]   pay_dec;

    assign s_tready = (count_reg != 2'd2);
    assign s_accept = s_tvalid && s_tready;

    // Parser: next state and result group for the byte on the input
    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        lsize_next   = lsize_reg;
        accum_next   = accum_reg;
        pbl_next     = pbl_reg;
        payload_next = payload_reg;
        emit         = 1'b0;
        grp_new      = '{data: s_tdata, is_sc: 1'b0, hdr: 1'b0};

        total   = (phase_reg == avclp_pkg::PH_NALU_LEN) ? lsize_reg
                                                         : avclp_pkg::HDR_LEN_BYTES;
        acc_new = {accum_reg[avclp_pkg::LEN_W-9:0], s_tdata};
        pbl_dec = (pbl_reg != '0) ? pbl_reg - 3'd1 : '0;
        pay_dec = (payload_reg != '0) ? payload_reg - 32'd1 : '0;

        if (s_tuser[0]) begin
            pos_next     = 4'd1;
            accum_next   = '0;
            pbl_next     = '0;
            payload_next = '0;
            phase_next   = (s_tdata[3:0] == avclp_pkg::CODEC_AVC) ? avclp_pkg::PH_TYPE
                                                                  : avclp_pkg::PH_IDLE;
        end else begin
            if (pos_reg != avclp_pkg::POS_MAX) begin
                pos_next = pos_reg + 4'd1;
            end
            unique case (phase_reg)
                avclp_pkg::PH_TYPE: begin
                    if (s_tdata == avclp_pkg::PKT_SEQ_HDR) begin
                        phase_next = avclp_pkg::PH_PRE_HDR;
                    end else if (s_tdata == avclp_pkg::PKT_NALU) begin
                        phase_next = avclp_pkg::PH_PRE_NALU;
                    end else begin
                        phase_next = avclp_pkg::PH_IDLE;
                    end
                end
                avclp_pkg::PH_PRE_HDR: begin
                    if (pos_reg == avclp_pkg::CFG_LEN_POS) begin
                        lsize_next = {1'b0, s_tdata[1:0] & avclp_pkg::LEN_MASK} + 3'd1;
                    end
                    if (pos_reg >= avclp_pkg::POS_HDR_END) begin
                        phase_next = avclp_pkg::PH_SPS_LEN;
                        pbl_next   = avclp_pkg::HDR_LEN_BYTES;
                        accum_next = '0;
                    end
                end
                avclp_pkg::PH_PRE_NALU: begin
                    if (pos_reg >= avclp_pkg::POS_NALU_END) begin
                        phase_next = avclp_pkg::PH_NALU_LEN;
                        pbl_next   = lsize_reg;
                        accum_next = '0;
                    end
                end
                avclp_pkg::PH_PPS_COUNT: begin
                    phase_next = avclp_pkg::PH_PPS_LEN;
                    pbl_next   = avclp_pkg::HDR_LEN_BYTES;
                    accum_next = '0;
                end
                avclp_pkg::PH_SPS_LEN, avclp_pkg::PH_PPS_LEN, avclp_pkg::PH_NALU_LEN: begin
                    // Start code goes out with the first byte of the length field
                    emit          = (pbl_reg == total) || (pbl_reg == '0);
                    grp_new.is_sc = 1'b1;
                    grp_new.hdr   = (phase_reg != avclp_pkg::PH_NALU_LEN);
                    accum_next    = acc_new;
                    pbl_next      = pbl_dec;
                    if (pbl_dec == '0) begin
                        payload_next = acc_new;
                        if (acc_new != '0) begin
                            phase_next = avclp_pkg::phase_t'(phase_reg + 4'd1);
                        end else if (phase_reg == avclp_pkg::PH_NALU_LEN) begin
                            pbl_next   = lsize_reg;
                            accum_next = '0;
                        end else if (phase_reg == avclp_pkg::PH_SPS_LEN) begin
                            phase_next = avclp_pkg::PH_PPS_COUNT;
                        end else begin
                            phase_next = avclp_pkg::PH_IDLE;
                        end
                    end
                end
                avclp_pkg::PH_SPS_DATA, avclp_pkg::PH_PPS_DATA, avclp_pkg::PH_NALU_DATA: begin
                    emit         = 1'b1;
                    grp_new.hdr  = (phase_reg != avclp_pkg::PH_NALU_DATA);
                    payload_next = pay_dec;
                    if (pay_dec == '0) begin
                        if (phase_reg == avclp_pkg::PH_NALU_DATA) begin
                            phase_next = avclp_pkg::PH_NALU_LEN;
                            pbl_next   = lsize_reg;
                            accum_next = '0;
                        end else if (phase_reg == avclp_pkg::PH_SPS_DATA) begin
                            phase_next = avclp_pkg::PH_PPS_COUNT;
                        end else begin
                            phase_next = avclp_pkg::PH_IDLE;
                        end
                    end
                end
                default: begin
                    phase_next = avclp_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= avclp_pkg::PH_IDLE;
            pos_reg     <= '0;
            lsize_reg   <= avclp_pkg::LSIZE_RESET;
            accum_reg   <= '0;
            pbl_reg     <= '0;
            payload_reg <= '0;
        end else if (s_accept) begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            lsize_reg   <= lsize_next;
            accum_reg   <= accum_next;
            pbl_reg     <= pbl_next;
            payload_reg <= payload_next;
        end
    end

    // Output side: group queue and start-code beat counter
    assign head     = grp_mem_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = head.is_sc ? avclp_pkg::START_CODE_WORD[8*beat_reg +: 8] : head.data;
    assign m_tuser  = {head.hdr, head.is_sc};
    assign m_tlast  = !head.is_sc || (beat_reg == 2'd3);
    assign m_accept = m_tvalid && m_tready;
    assign pop      = m_accept && m_tlast;
    assign push     = s_accept && emit;

    always_ff @(posedge aclk) begin
        if (push) begin
            grp_mem_reg[wr_ptr_reg] <= grp_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            beat_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
                beat_reg   <= 2'd0;
            end else if (m_accept) begin
                beat_reg <= beat_reg + 2'd1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("group queue count out of range");

    a_beat_in_sc: assert property (@(posedge aclk) disable iff (!aresetn)
        (beat_reg != 2'd0) |-> (m_tvalid && head.is_sc))
        else $error("start-code beat counter running without a start-code group");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count missed a push");

    a_beat_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (beat_reg == $past(beat_reg)))
        else $error("start-code beat advanced during a stall");
`endif

endmodule
